[rtl/lpfr_pkg.sv]
package lpfr_pkg;

  // default ring size in bytes
  localparam int BUFFER_BYTES_DEF = 256;

  // frame header layout
  localparam int HDR_BYTES   = 12;
  localparam int OFF_CMD_LO  = 4;
  localparam int OFF_CMD_HI  = 5;
  localparam int OFF_CSUM    = 7;
  localparam int OFF_PID_LO  = 8;
  localparam int OFF_PID_HI  = 9;
  localparam int OFF_ADDR_LO = 10;
  localparam int OFF_ADDR_HI = 11;
  localparam int LEN_BYTES   = 4;
  localparam int REP_READS   = 5;

  // command codes
  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  // status codes
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

endpackage

[rtl/lpfr_ring.sv]
module lpfr_ring import lpfr_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int AW = $clog2(BUFFER_BYTES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [BUFFER_BYTES];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/length_prefixed_frame_receiver_core.sv]
// channel  | handshake             | word
// ---------+-----------------------+---------------------------------------------
// in       | in_valid / in_stall   | cmd, rx_byte, read_offset
// out      | out_valid / out_stall | status, frame_ready, frame_command,
//          |                       | frame_packet_id, payload_length, read_data
// cfg      | cfg_we                | cfg_wdata (match address)
//
// one word at a time; in_stall is high from acceptance until the result is taken.
// read, release: fetch of the header fields and data byte in S_REP, then the output state.
// push: a search step in S_TOP, then as the buffered bytes allow a length fetch and a checksum pass,
// then the S_REP fetches; a checksum failure repeats the search, so a push can take many passes.
// rst is synchronous and clears the sequencer state, pointers, counts and held frame; ring contents stay undefined.
// a stalled result holds its fields until out_stall drops.
module length_prefixed_frame_receiver_core import lpfr_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  read_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        frame_ready,
  output logic [15:0] frame_command,
  output logic [15:0] frame_packet_id,
  output logic [7:0]  payload_length,
  output logic [7:0]  read_data
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 2);
  localparam int SW = CW + 1;
  localparam int LW = ((CW > 9) ? CW : 9) + 1;
  localparam logic [SW-1:0] BUF_S = SW'(BUFFER_BYTES);
  localparam logic [CW-1:0] BUF_C = CW'(BUFFER_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_TOP, S_LEN, S_SUM, S_REP, S_OUT
  } state_t;

  state_t        state;
  logic [15:0]   match_addr;
  logic [AW-1:0] start;
  logic [CW-1:0] count;
  logic [CW-1:0] exp_len;
  logic [AW-1:0] held_start;
  logic [CW-1:0] held_length;
  logic          held;
  logic [CW-1:0] idx;
  logic [CW-1:0] pidx;
  logic          pend;
  logic [7:0]    sum;
  logic [7:0]    b7, a10, a11;
  logic [7:0]    len0, len1, len2, len3;
  logic [7:0]    cmd_lo, cmd_hi, pid_lo, pid_hi, rdat;
  logic          rd_ok;
  logic          refused;
  logic [7:0]    roff;

  // wrap base + offset into the ring, offset never above the ring size
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] b, input logic [CW-1:0] o);
    logic [SW-1:0] s;
    s = SW'(b) + SW'(o);
    if (s >= BUF_S) begin
      s = s - BUF_S;
    end
    return s[AW-1:0];
  endfunction

  // shared address unit and fetch limit
  logic [AW-1:0] a_base;
  logic [CW-1:0] a_off;
  logic [AW-1:0] a_addr;
  logic [CW-1:0] limit;
  logic          issue;
  logic          done;
  logic [7:0]    rd;
  logic [CW-1:0] cnt_clamp;
  logic [31:0]   len_word;
  logic [CW-1:0] roff_ext;

  assign roff_ext = rd_ok ? CW'(32'(roff) + HDR_BYTES) : '0;

  always_comb begin
    a_base = start;
    a_off  = idx;
    limit  = '0;
    case (state)
      S_IDLE: begin
        a_off = count;
      end
      S_LEN: begin
        limit = CW'(LEN_BYTES);
      end
      S_SUM: begin
        limit = exp_len;
      end
      S_REP: begin
        a_base = held_start;
        limit  = CW'(REP_READS);
        case (idx[2:0])
          3'd0:    a_off = CW'(OFF_CMD_LO);
          3'd1:    a_off = CW'(OFF_CMD_HI);
          3'd2:    a_off = CW'(OFF_PID_LO);
          3'd3:    a_off = CW'(OFF_PID_HI);
          default: a_off = roff_ext;
        endcase
      end
      default: begin
        limit = '0;
      end
    endcase
    a_addr = wrap(a_base, a_off);
  end

  assign issue     = (idx < limit);
  assign done      = !issue && !pend;
  assign cnt_clamp = (count > BUF_C) ? '0 : count;
  assign len_word  = {len3, len2, len1, len0};

  lpfr_ring #(.BUFFER_BYTES(BUFFER_BYTES)) u_ring (
    .clk   (clk),
    .we    (state == S_IDLE && in_valid && cmd == CMD_PUSH),
    .waddr (a_addr),
    .wdata (rx_byte),
    .raddr (a_addr),
    .rdata (rd)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      match_addr  <= '0;
      start       <= '0;
      count       <= '0;
      exp_len     <= '0;
      held_start  <= '0;
      held_length <= '0;
      held        <= 1'b0;
      idx         <= '0;
      pend        <= 1'b0;
    end else begin
      if (cfg_we) begin
        match_addr <= cfg_wdata;
      end
      // pipelined ring fetch, shared by the length, checksum and report phases
      if (state == S_LEN || state == S_SUM || state == S_REP) begin
        pend <= issue;
        pidx <= idx;
        if (issue) begin
          idx <= idx + 1'b1;
        end
      end
      case (state)
        S_IDLE: begin
          idx     <= '0;
          pend    <= 1'b0;
          refused <= 1'b0;
          rd_ok   <= 1'b0;
          roff    <= read_offset;
          if (in_valid) begin
            case (cmd)
              CMD_PUSH: begin
                count <= count + 1'b1;
                state <= S_TOP;
              end
              CMD_READ: begin
                if (held && LW'(read_offset) + LW'(HDR_BYTES) < LW'(held_length)) begin
                  rd_ok <= 1'b1;
                end else begin
                  refused <= 1'b1;
                end
                state <= S_REP;
              end
              CMD_RELEASE: begin
                if (held) begin
                  held <= 1'b0;
                end else begin
                  refused <= 1'b1;
                end
                state <= S_REP;
              end
              default: begin
                state <= S_REP;
              end
            endcase
          end
        end
        S_TOP: begin
          count <= cnt_clamp;
          idx   <= '0;
          pend  <= 1'b0;
          sum   <= '0;
          if (cnt_clamp > CW'(3) && exp_len == '0) begin
            state <= S_LEN;
          end else if (exp_len != '0 && cnt_clamp >= exp_len
                       && cnt_clamp > CW'(OFF_ADDR_HI)) begin
            state <= S_SUM;
          end else begin
            state <= S_REP;
          end
        end
        S_LEN: begin
          if (pend) begin
            case (pidx[1:0])
              2'd0:    len0 <= rd;
              2'd1:    len1 <= rd;
              2'd2:    len2 <= rd;
              default: len3 <= rd;
            endcase
          end
          if (done) begin
            idx <= '0;
            if (len_word > 32'(BUFFER_BYTES) || len_word < 32'(HDR_BYTES)) begin
              // bad length: slide by one byte
              exp_len <= '0;
              start   <= wrap(start, CW'(1));
              if (count != '0) begin
                count <= count - 1'b1;
              end
              state <= S_REP;
            end else begin
              exp_len <= len_word[CW-1:0];
              if (count >= len_word[CW-1:0] && count > CW'(OFF_ADDR_HI)) begin
                state <= S_SUM;
              end else begin
                state <= S_REP;
              end
            end
          end
        end
        S_SUM: begin
          if (pend) begin
            if (pidx == CW'(OFF_CSUM)) begin
              b7 <= rd;
            end else begin
              sum <= sum + rd;
            end
            if (pidx == CW'(OFF_ADDR_LO)) begin
              a10 <= rd;
            end
            if (pidx == CW'(OFF_ADDR_HI)) begin
              a11 <= rd;
            end
          end
          if (done) begin
            idx <= '0;
            if (sum != b7) begin
              // checksum error: slide and search again
              exp_len <= '0;
              start   <= wrap(start, CW'(1));
              if (count != '0) begin
                count <= count - 1'b1;
              end
              state <= S_TOP;
            end else begin
              if ({a11, a10} == match_addr) begin
                held_start  <= start;
                held_length <= exp_len;
                held        <= 1'b1;
              end
              start   <= wrap(start, exp_len);
              count   <= count - exp_len;
              exp_len <= '0;
              state   <= S_REP;
            end
          end
        end
        S_REP: begin
          if (pend) begin
            case (pidx[2:0])
              3'd0:    cmd_lo <= rd;
              3'd1:    cmd_hi <= rd;
              3'd2:    pid_lo <= rd;
              3'd3:    pid_hi <= rd;
              default: rdat   <= rd;
            endcase
          end
          if (done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result word
  logic [LW-1:0] plen;
  assign plen            = LW'(held_length) - LW'(HDR_BYTES);
  assign in_stall        = (state != S_IDLE);
  assign out_valid       = (state == S_OUT);
  assign status          = refused ? ST_REFUSED : (held ? ST_READY : ST_NONE);
  assign frame_ready     = held;
  assign frame_command   = held ? {cmd_hi, cmd_lo} : 16'd0;
  assign frame_packet_id = held ? {pid_hi, pid_lo} : 16'd0;
  assign payload_length  = held ? plen[7:0] : 8'd0;
  assign read_data       = rd_ok ? rdat : 8'd0;

endmodule

[rtl/lpfr_checker.sv]
module lpfr_props import lpfr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic        frame_ready,
  input logic [15:0] frame_command,
  input logic [7:0]  payload_length
);

  // an accepted word closes the input until its result goes out
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after accept");

  // no new word while a result waits
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // status agrees with frame_ready
  a_status_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_READY || status == ST_NONE) |->
      (frame_ready == (status == ST_READY)))
    else $error("status and frame_ready disagree");

  // no frame held means empty command and payload length
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_ready |-> frame_command == 16'd0 && payload_length == 8'd0)
    else $error("fields set with no frame held");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(frame_command))
    else $error("stalled result changed");

endmodule

bind length_prefixed_frame_receiver_core lpfr_props u_lpfr_props (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .frame_ready    (frame_ready),
  .frame_command  (frame_command),
  .payload_length (payload_length)
);
